[sv/upd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared constants, the result bundle type and the hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned MAX_RESULTS     = 3;
  localparam int unsigned RES_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W       = $clog2(MAX_RESULTS);

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'hFFFF;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_PCT        = 8'h25;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_LOWER_BASE = 8'h57;
  localparam logic [7:0] CH_UPPER_BASE = 8'h37;

  typedef struct packed {
    logic [RES_CNT_W-1:0]         cnt;
    logic [MAX_RESULTS-1:0][7:0]  data;
    logic [MAX_RESULTS-1:0]       vld;
    logic [MAX_RESULTS-1:0]       fin;
  } bundle_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - CH_ZERO;
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - CH_LOWER_BASE;
    end else begin
      d = b - CH_UPPER_BASE;
    end
    hex_val = d[3:0];
  endfunction

endpackage
`default_nettype wire

[sv/upd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Classifies each request byte, tracks escape and limit state and builds
// the bundle of up to three results that the byte causes.
// ----------------------------------------------------------------------------
module upd_front #(
  parameter int unsigned COUNT_WIDTH = upd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [7:0]                in_byte,
  input  wire logic [upd_pkg::LEN_W-1:0] max_length,
  output logic                           push,
  output upd_pkg::bundle_t               bundle
);

  localparam int unsigned CMP_W =
    ((COUNT_WIDTH > upd_pkg::LEN_W) ? COUNT_WIDTH : upd_pkg::LEN_W) + 2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             digit_r, digit_nxt;
  logic [COUNT_WIDTH-1:0] cons_r, cons_nxt;
  logic [COUNT_WIDTH-1:0] prod_r, prod_nxt;
  logic                   lim_r, lim_nxt;

  logic [1:0]                    pre_en;
  logic [1:0][7:0]               pre_byte;
  logic                          run_idle;
  logic                          hex_ok;
  logic [upd_pkg::RES_CNT_W-1:0] n;
  upd_pkg::bundle_t              bnd;

  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    cons_nxt  = cons_r;
    prod_nxt  = prod_r;
    lim_nxt   = lim_r;
    pre_en    = 2'b00;
    pre_byte  = {digit_r, upd_pkg::CH_PCT};
    run_idle  = 1'b0;
    n         = '0;
    bnd       = '0;
    hex_ok    = (in_byte != upd_pkg::CH_NUL) && upd_pkg::is_hex(in_byte);

    case (phase_r)
      PH_PCT: begin
        if (hex_ok) begin
          digit_nxt = in_byte;
          phase_nxt = PH_DIG;
        end else begin
          phase_nxt = PH_IDLE;
          pre_en    = 2'b01;
          run_idle  = 1'b1;
        end
      end
      PH_DIG: begin
        phase_nxt = PH_IDLE;
        digit_nxt = '0;
        if (hex_ok) begin
          bnd.data[0] = {upd_pkg::hex_val(digit_r), upd_pkg::hex_val(in_byte)};
          bnd.vld[0]  = 1'b1;
          n           = upd_pkg::RES_CNT_W'(1);
          cons_nxt    = cons_r + COUNT_WIDTH'(3);
          prod_nxt    = prod_r + 1'b1;
          if (CMP_W'(cons_nxt) >= CMP_W'(max_length)) begin
            lim_nxt = 1'b1;
          end
        end else begin
          pre_en   = 2'b11;
          run_idle = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        run_idle  = 1'b1;
      end
    endcase

    for (int k = 0; k < 2; k++) begin
      if (pre_en[k] && !lim_nxt) begin
        bnd.data[n[upd_pkg::RES_IDX_W-1:0]] = pre_byte[k];
        bnd.vld[n[upd_pkg::RES_IDX_W-1:0]]  = 1'b1;
        n        = n + 1'b1;
        cons_nxt = cons_nxt + 1'b1;
        prod_nxt = prod_nxt + 1'b1;
        if (CMP_W'(cons_nxt) >= CMP_W'(max_length)) begin
          lim_nxt = 1'b1;
        end
      end
    end

    if (run_idle) begin
      if (in_byte == upd_pkg::CH_NUL) begin
        bnd.data[n[upd_pkg::RES_IDX_W-1:0]] = upd_pkg::CH_NUL;
        bnd.vld[n[upd_pkg::RES_IDX_W-1:0]]  =
          (CMP_W'(prod_nxt) < CMP_W'(max_length));
        bnd.fin[n[upd_pkg::RES_IDX_W-1:0]]  = 1'b1;
        n         = n + 1'b1;
        phase_nxt = PH_IDLE;
        digit_nxt = '0;
        cons_nxt  = '0;
        prod_nxt  = '0;
        lim_nxt   = 1'b0;
      end else if (lim_nxt) begin
        // drop
      end else if (in_byte == upd_pkg::CH_PCT &&
                   (CMP_W'(cons_nxt) + CMP_W'(3)) <= CMP_W'(max_length)) begin
        phase_nxt = PH_PCT;
      end else begin
        bnd.data[n[upd_pkg::RES_IDX_W-1:0]] =
          (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;
        bnd.vld[n[upd_pkg::RES_IDX_W-1:0]]  = 1'b1;
        n        = n + 1'b1;
        cons_nxt = cons_nxt + 1'b1;
        prod_nxt = prod_nxt + 1'b1;
        if (CMP_W'(cons_nxt) >= CMP_W'(max_length)) begin
          lim_nxt = 1'b1;
        end
      end
    end
    bnd.cnt = n;
  end

  assign push   = accept && (n != '0);
  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      digit_r <= '0;
      cons_r  <= '0;
      prod_r  <= '0;
      lim_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
      cons_r  <= cons_nxt;
      prod_r  <= prod_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/upd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder bundle queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module upd_queue #(
  parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire upd_pkg::bundle_t push_data,
  input  wire logic             pop,
  output upd_pkg::bundle_t      head,
  output logic                  not_empty,
  output logic                  full
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  upd_pkg::bundle_t   store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head      = store_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/upd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Unpacks each queued bundle into single results through the output register.
// ----------------------------------------------------------------------------
module upd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire upd_pkg::bundle_t head,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_valid_byte,
  output logic                  out_end
);

  logic [upd_pkg::RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                          ov_r, ov_nxt;
  logic [7:0]                    byte_r;
  logic                          vb_r;
  logic                          end_r;
  logic                          load;
  logic                          last;

  assign load = head_valid && (!ov_r || out_ready);
  assign last = (upd_pkg::RES_CNT_W'(idx_r) + 1'b1) == head.cnt;
  assign pop  = load && last;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      ov_nxt  = 1'b1;
      idx_nxt = last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.data[idx_r];
      vb_r   <= head.vld[idx_r];
      end_r  <= head.fin[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = byte_r;
  assign out_valid_byte = vb_r;
  assign out_end        = end_r;

endmodule
`default_nettype wire

[sv/url_percent_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder unit
// Decodes a zero-terminated URL-encoded byte stream, one request byte at a
// time, into decoded bytes and an end-of-string result.
//
// Channels: in_valid/in_ready/in_byte carry encoded bytes; out_valid/
// out_ready carry results (out_byte, out_valid_byte, out_end); cfg_valid/
// cfg_ready/cfg_data write max_length, taken at once (cfg_ready is tied high).
// Path: a byte's first result goes into the queue, then the output register.
// Throughput: one byte per cycle while out_ready is high and each byte
// gives at most one result; a failed escape gives up to three results.
// The output port of the back end, one result per cycle, sets this.
// The '%' and first digit of an escape and dropped bytes give none.
// Reset: all string state clears, max_length returns to 65535, the queue
// empties; no clearing pass.
// Stall: when out_ready is low, results hold in the output register, bundles
// gather in the queue and in_ready falls once the queue is full.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit #(
  parameter int unsigned COUNT_WIDTH = upd_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_valid_byte,
  output logic                           out_end,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [upd_pkg::LEN_W-1:0] cfg_data
);

  logic [upd_pkg::LEN_W-1:0] max_length_r;
  logic                      accept;
  logic                      push;
  logic                      pop;
  logic                      q_valid;
  logic                      q_full;
  upd_pkg::bundle_t          push_bundle;
  upd_pkg::bundle_t          head_bundle;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= upd_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_data;
    end
  end

  upd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_byte),
    .max_length (max_length_r),
    .push       (push),
    .bundle     (push_bundle)
  );

  upd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_bundle),
    .pop       (pop),
    .head      (head_bundle),
    .not_empty (q_valid),
    .full      (q_full)
  );

  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head_bundle),
    .head_valid     (q_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_valid_byte (out_valid_byte),
    .out_end        (out_end)
  );

endmodule
`default_nettype wire

[verif/tb_url_percent_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder unit testbench
// Feeds zero-terminated encoded strings through the request channel under
// bursty sending and patterned output stalls. A short directed table covers
// plain bytes, '+', good and broken escapes, the limit and its extremes;
// random strings under random limits follow. A behavioural decoder kept in
// step with each accepted request predicts results for them and some rows.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_unit;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       fin;
  } dec_res_t;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_DIG  = 2'd2;

  localparam logic [1:0] ROW_PRED = 2'd0;
  localparam logic [1:0] ROW_NONE = 2'd1;
  localparam logic [1:0] ROW_ONE  = 2'd2;
  localparam logic [1:0] ROW_CFG  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] val;
    dec_res_t    res;
  } row_t;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 230;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_byte   = 8'h00;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_byte;
  logic                      out_valid_byte;
  logic                      out_end;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [upd_pkg::LEN_W-1:0] cfg_data  = '0;

  logic [1:0]  esc_st;
  logic [7:0]  held_dig;
  logic [15:0] n_in;
  logic [15:0] n_out;
  logic        at_limit;
  logic [15:0] max_len;

  dec_res_t    step_results [$];
  dec_res_t    owed_results [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned fed_bytes   = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;

  url_percent_decoder_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_valid_byte (out_valid_byte),
    .out_end        (out_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic is_hex_char(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] b);
    logic [7:0] v;
    if (b >= "0" && b <= "9") begin
      v = b - "0";
    end else if (b >= "a" && b <= "f") begin
      v = b - "a" + 8'd10;
    end else begin
      v = b - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] any_hex();
    int unsigned n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'("0" + n);
    if (n < 16) return 8'("a" + n - 10);
    return 8'("A" + n - 16);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (is_hex_char(b));
    return b;
  endfunction

  function automatic row_t pred_row(logic [7:0] b);
    return '{ROW_PRED, {8'h00, b}, '0};
  endfunction

  function automatic row_t none_row(logic [7:0] b);
    return '{ROW_NONE, {8'h00, b}, '0};
  endfunction

  function automatic row_t one_row(logic [7:0] b, logic [7:0] d, logic v, logic f);
    return '{ROW_ONE, {8'h00, b}, '{d, v, f}};
  endfunction

  function automatic row_t cfg_row(logic [15:0] v);
    return '{ROW_CFG, v, '0};
  endfunction

  task automatic clear_string();
    esc_st   = ESC_IDLE;
    held_dig = 8'h00;
    n_in     = '0;
    n_out    = '0;
    at_limit = 1'b0;
  endtask

  task automatic emit(logic [7:0] d, logic v, logic f);
    step_results.push_back('{d, v, f});
  endtask

  task automatic count_out(logic [15:0] k);
    n_in  = n_in + k;
    n_out = n_out + 16'd1;
    if (n_in >= max_len) at_limit = 1'b1;
  endtask

  task automatic emit_plain(logic [7:0] b);
    if (!at_limit) begin
      emit(b, 1'b1, 1'b0);
      count_out(16'd1);
    end
  endtask

  task automatic idle_byte(logic [7:0] b);
    if (b == upd_pkg::CH_NUL) begin
      emit(upd_pkg::CH_NUL, n_out < max_len, 1'b1);
      clear_string();
    end else if (at_limit) begin
    end else if (b == upd_pkg::CH_PCT && int'(n_in) + 3 <= int'(max_len)) begin
      esc_st = ESC_PCT;
    end else if (b == upd_pkg::CH_PLUS) begin
      emit_plain(upd_pkg::CH_SPACE);
    end else begin
      emit_plain(b);
    end
  endtask

  task automatic decode_byte(logic [7:0] b);
    step_results.delete();
    case (esc_st)
      ESC_PCT: begin
        if (b != upd_pkg::CH_NUL && is_hex_char(b)) begin
          held_dig = b;
          esc_st   = ESC_DIG;
        end else begin
          esc_st = ESC_IDLE;
          emit_plain(upd_pkg::CH_PCT);
          idle_byte(b);
        end
      end
      ESC_DIG: begin
        esc_st = ESC_IDLE;
        if (b != upd_pkg::CH_NUL && is_hex_char(b)) begin
          emit({nibble(held_dig), nibble(b)}, 1'b1, 1'b0);
          count_out(16'd3);
        end else begin
          emit_plain(upd_pkg::CH_PCT);
          emit_plain(held_dig);
          idle_byte(b);
        end
        held_dig = 8'h00;
      end
      default: begin
        esc_st = ESC_IDLE;
        idle_byte(b);
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_request(logic [7:0] b, logic [1:0] kind, dec_res_t typed);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    decode_byte(b);
    if (kind == ROW_PRED) begin
      foreach (step_results[i]) owed_results.push_back(step_results[i]);
    end else if (kind == ROW_ONE) begin
      owed_results.push_back(typed);
    end
    fed_bytes++;
    @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic put_plain(logic [7:0] b);
    put_request(b, ROW_PRED, '0);
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 9) >= 3);
      2:       out_ready <= (stall_left % 3 != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    dec_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got byte %h valid %b end %b",
                 $time, out_byte, out_valid_byte, out_end);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h got %h", $time, want.data, out_byte);
          mismatches++;
        end
        if (out_valid_byte !== want.vld) begin
          $display("%0t: out_valid_byte expected %b got %b", $time, want.vld,
                   out_valid_byte);
          mismatches++;
        end
        if (out_end !== want.fin) begin
          $display("%0t: out_end expected %b got %b", $time, want.fin, out_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_url_percent_decoder_unit: FAIL");
      $finish;
    end
  end

  initial begin
    row_t        plan [$];
    logic [15:0] lim;
    int unsigned pick;

    plan = '{
      one_row("A", "A", 1'b1, 1'b0),
      one_row(upd_pkg::CH_PLUS, upd_pkg::CH_SPACE, 1'b1, 1'b0),
      one_row(8'hFF, 8'hFF, 1'b1, 1'b0),
      none_row(upd_pkg::CH_PCT),
      none_row("A"),
      one_row("f", 8'hAF, 1'b1, 1'b0),
      none_row(upd_pkg::CH_PCT),
      pred_row("g"),
      none_row(upd_pkg::CH_PCT),
      none_row("1"),
      pred_row(upd_pkg::CH_PLUS),
      none_row(upd_pkg::CH_PCT),
      pred_row(upd_pkg::CH_NUL),
      one_row(upd_pkg::CH_NUL, upd_pkg::CH_NUL, 1'b1, 1'b1),
      cfg_row(16'd3),
      one_row("a", "a", 1'b1, 1'b0),
      one_row("b", "b", 1'b1, 1'b0),
      one_row("c", "c", 1'b1, 1'b0),
      none_row("d"),
      one_row(upd_pkg::CH_NUL, upd_pkg::CH_NUL, 1'b0, 1'b1),
      cfg_row(16'd4),
      one_row("x", "x", 1'b1, 1'b0),
      none_row(upd_pkg::CH_PCT),
      none_row("4"),
      one_row("1", 8'h41, 1'b1, 1'b0),
      one_row(upd_pkg::CH_NUL, upd_pkg::CH_NUL, 1'b1, 1'b1),
      cfg_row(16'd0),
      one_row("z", "z", 1'b1, 1'b0),
      one_row(upd_pkg::CH_NUL, upd_pkg::CH_NUL, 1'b0, 1'b1)
    };

    max_len = upd_pkg::MAX_LENGTH_RST;
    clear_string();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_limit(plan[i].val);
      end else begin
        put_request(plan[i].val[7:0], plan[i].kind, plan[i].res);
      end
    end

    fed_bytes = 0;
    while (fed_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 6))
        0:       lim = 16'd1;
        1:       lim = 16'd2;
        2:       lim = 16'd3;
        3:       lim = 16'hFFFF;
        4:       lim = 16'($urandom_range(4, 24));
        default: lim = 16'($urandom_range(1, 65535));
      endcase
      write_limit(lim);
      repeat ($urandom_range(3, 6)) begin
        repeat ($urandom_range(0, 14)) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            put_plain(8'($urandom_range(8'h21, 8'h7E)));
          end else if (pick < 50) begin
            put_plain(upd_pkg::CH_PLUS);
          end else if (pick < 72) begin
            put_plain(upd_pkg::CH_PCT);
            put_plain(any_hex());
            put_plain(any_hex());
          end else if (pick < 80) begin
            put_plain(upd_pkg::CH_PCT);
            put_plain(non_hex());
          end else if (pick < 86) begin
            put_plain(upd_pkg::CH_PCT);
            put_plain(any_hex());
            put_plain(non_hex());
          end else if (pick < 96) begin
            put_plain(8'($urandom_range(1, 255)));
          end else begin
            put_plain(upd_pkg::CH_PCT);
          end
        end
        put_plain(upd_pkg::CH_NUL);
      end
    end

    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_url_percent_decoder_unit: PASS");
    end else begin
      $display("tb_url_percent_decoder_unit: FAIL");
    end
    $finish;
  end

endmodule
